// ===== rtl/multi_rate_periodic_event_scheduler_defines.svh =====
`ifndef MULTI_RATE_PERIODIC_EVENT_SCHEDULER_DEFINES_SVH
`define MULTI_RATE_PERIODIC_EVENT_SCHEDULER_DEFINES_SVH

// same-cycle implication, checked on the rising clock edge outside reset
`define MRPES_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked on the rising clock edge outside reset
`define MRPES_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/mrpes_pkg.sv =====
`default_nettype none

package mrpes_pkg;

   localparam logic [1:0] OP_REGISTER = 2'd0;
   localparam logic [1:0] OP_ADVANCE  = 2'd1;
   localparam logic [1:0] OP_LEAVE    = 2'd2;
   localparam logic [1:0] OP_RESTART  = 2'd3;

   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_FULL      = 2'd1;
   localparam logic [1:0] STAT_NOT_FOUND = 2'd2;

   localparam logic CSR_PAUSED   = 1'b0;
   localparam logic CSR_IDLE_ADV = 1'b1;

   localparam logic        PAUSED_RESET   = 1'b1;
   localparam logic [31:0] IDLE_ADV_RESET = 32'd1000000;
   localparam logic [29:0] US_PER_MS      = 30'd1000;
   localparam logic [15:0] HANDLE_RESET   = 16'd1;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SCAN_INIT,
      ST_SCAN,
      ST_REG_CHECK,
      ST_REG_APPLY,
      ST_LEAVE_CHECK,
      ST_LEAVE_APPLY,
      ST_LEAVE_FIND,
      ST_ADV_CHECK,
      ST_FIRE_TIME,
      ST_RST_INIT,
      ST_RST_PICK,
      ST_RST_MUL,
      ST_DUE_WR,
      ST_INS_SCAN,
      ST_INS_SHIFT,
      ST_DONE
   } ctrl_state_type;

   typedef enum logic [1:0] {
      RA_SCAN,
      RA_QUEUE,
      RA_SEL
   } ra_sel_type;

   typedef struct packed {
      ra_sel_type ra;
      logic       load;
      logic       scan_start;
      logic       scan_run;
      logic       stat_full;
      logic       stat_not_found;
      logic       reg_pick;
      logic       reg_apply;
      logic       leave_pick;
      logic       leave_apply;
      logic       find_step;
      logic       idle_adv;
      logic       fire_sel;
      logic       fire_time;
      logic       rst_init;
      logic       rst_pick;
      logic       mul_period;
      logic       due_wr;
      logic       ins_step;
      logic       ins_shift;
   } dp_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic reg_ok;
      logic slot_hit;
      logic leave_ok;
      logic last_member;
      logic find_done;
      logic paused;
      logic q_empty;
      logic best_found;
      logic ins_stop;
   } dp_stat_type;

   function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/multi_rate_periodic_event_scheduler.sv =====
// sequence: register and leave scan max(members, slots) entries, then may do queue work;
// advance fires the queue head or adds the idle step; restart runs (valid slots + 1) scans
// throughput: one transaction at a time, limited by the serial table scan (one entry a cycle)
// and the one-position-a-cycle search of the ordered queue
// reset: synchronous, clears time, valid bits and queue count, handle counter to 1; paused set,
// idle advance 1000000 us; result strobe lasts one cycle, the receiver cannot stall
`default_nettype none
`include "multi_rate_periodic_event_scheduler_defines.svh"

module multi_rate_periodic_event_scheduler import mrpes_pkg::*; #(
   parameter int PERIOD_SLOTS = 16,
   parameter int MEMBER_SLOTS = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // command transaction
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_operation,
   input  wire logic [31:0] req_member_id,
   input  wire logic [19:0] req_step_ms,
   // result transaction, one cycle strobe
   output logic             rsp_valid,
   output logic [1:0]       rsp_status,
   output logic [15:0]      rsp_handle,
   output logic             rsp_fired,
   output logic [31:0]      rsp_time_us,
   // register port
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // configuration registers
   logic        paused_ff;
   logic [31:0] idle_adv_ff;
   logic        csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         paused_ff   <= PAUSED_RESET;
         idle_adv_ff <= IDLE_ADV_RESET;
      end else if (csr_write) begin
         // word address picks the register, low byte bits ignored
         if (paddr[2] == CSR_PAUSED) paused_ff <= pwdata[0];
         else idle_adv_ff <= pwdata;
      end
   end

   always_comb begin
      case (paddr[2])
         CSR_IDLE_ADV: prdata = idle_adv_ff;
         default:      prdata = {31'd0, paused_ff};
      endcase
   end

   // sequencer: one state per step of the operation
   mrpes_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_operation (req_operation),
      .stat          (stat),
      .busy          (busy),
      .rsp_valid     (rsp_valid),
      .cmd           (cmd)
   );

   // slot table, member store, ordered queue and time base
   mrpes_datapath #(
      .PERIOD_SLOTS (PERIOD_SLOTS),
      .MEMBER_SLOTS (MEMBER_SLOTS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_member_id       (req_member_id),
      .req_step_ms         (req_step_ms),
      .cfg_paused          (paused_ff),
      .cfg_idle_advance_us (idle_adv_ff),
      .rsp_status          (rsp_status),
      .rsp_handle          (rsp_handle),
      .rsp_fired           (rsp_fired),
      .rsp_time_us         (rsp_time_us)
   );

   // the strobe is never held high
   `MRPES_ASSERT_NEXT(a_strobe_single, rsp_valid, !rsp_valid, "result strobe held")
   // an accepted transaction makes the block busy
   `MRPES_ASSERT_NEXT(a_busy_after_start, start && !busy, busy, "start not taken")
   // a result only appears while a transaction is in flight
   `MRPES_ASSERT_NOW(a_result_in_flight, rsp_valid, busy, "result while idle")
   // a delivered event always reports success
   `MRPES_ASSERT_NOW(a_fired_ok, rsp_valid && rsp_fired, rsp_status == STAT_OK, "fired not ok")

endmodule

`default_nettype wire

// ===== rtl/mrpes_datapath.sv =====
`default_nettype none

module mrpes_datapath import mrpes_pkg::*; #(
   parameter int PERIOD_SLOTS = 16,
   parameter int MEMBER_SLOTS = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire dp_cmd_type  cmd,
   output dp_stat_type      stat,
   input  wire logic [31:0] req_member_id,
   input  wire logic [19:0] req_step_ms,
   input  wire logic        cfg_paused,
   input  wire logic [31:0] cfg_idle_advance_us,
   output logic [1:0]       rsp_status,
   output logic [15:0]      rsp_handle,
   output logic             rsp_fired,
   output logic [31:0]      rsp_time_us
);

   localparam int PW  = (PERIOD_SLOTS > 1) ? $clog2(PERIOD_SLOTS) : 1;
   localparam int MW  = (MEMBER_SLOTS > 1) ? $clog2(MEMBER_SLOTS) : 1;
   localparam int CW  = $clog2(PERIOD_SLOTS + 1);
   localparam int SL  = (MEMBER_SLOTS > PERIOD_SLOTS) ? MEMBER_SLOTS : PERIOD_SLOTS;
   localparam int SCW = $clog2(SL + 1);
   localparam int MCW = $clog2(MEMBER_SLOTS + 1);

   // slot table
   logic            slot_valid_ff  [PERIOD_SLOTS];
   logic [15:0]     slot_handle_ff [PERIOD_SLOTS];
   logic [19:0]     slot_period_ff [PERIOD_SLOTS];
   logic [MCW-1:0]  slot_mcount_ff [PERIOD_SLOTS];
   logic [31:0]     slot_due_ff    [PERIOD_SLOTS];
   logic            placed_ff      [PERIOD_SLOTS];
   logic [PW-1:0]   pending_ff     [PERIOD_SLOTS];
   logic [CW-1:0]   count_ff;
   logic [CW-1:0]   qpos_ff;

   // member table
   logic            member_valid_ff [MEMBER_SLOTS];
   logic [PW+31:0]  member_ram      [MEMBER_SLOTS];
   logic [PW+31:0]  mem_q;
   logic            mv_q;

   // item registers
   logic [31:0]     id_ff;
   logic [19:0]     step_ff;
   logic [29:0]     prod_ff;
   logic [31:0]     time_ff;
   logic [31:0]     new_due_ff;
   logic [PW-1:0]   sel_ff;
   logic [15:0]     next_handle_ff;
   logic [1:0]      status_ff;
   logic [15:0]     handle_ff;
   logic            fired_ff;

   // scan
   logic [SCW-1:0]  idx_ff;
   logic [SCW-1:0]  st_idx_ff;
   logic            st_v_ff;
   logic            free_found_ff, hit_found_ff, fresh_found_ff, match_found_ff, best_found_ff;
   logic [MW-1:0]   free_m_ff, match_m_ff;
   logic [PW-1:0]   hit_slot_ff, fresh_slot_ff, match_slot_ff, best_slot_ff;
   logic [15:0]     best_handle_ff;

   logic [PW-1:0]   ra;
   logic            rd_valid;
   logic [15:0]     rd_handle;
   logic [19:0]     rd_period;
   logic [MCW-1:0]  rd_mcount;
   logic [31:0]     rd_due;
   logic            rd_placed;
   logic [MW-1:0]   m_addr;
   logic            st_m_ok, st_s_ok, scan_eval;
   logic [31:0]     due_sum, idle_sum;
   logic            ins_go, find_hit, q_in_range, do_remove;
   logic [MCW-1:0]  leave_cnt;
   logic [PW-1:0]   q_head, q_at_pos;

   assign q_head     = pending_ff[0];
   assign q_in_range = qpos_ff < count_ff;
   assign q_at_pos   = pending_ff[qpos_ff[PW-1:0]];

   always_comb begin
      case (cmd.ra)
         RA_SCAN:  ra = st_idx_ff[PW-1:0];
         RA_QUEUE: ra = q_at_pos;
         RA_SEL:   ra = sel_ff;
         default:  ra = sel_ff;
      endcase
   end

   assign rd_valid  = slot_valid_ff[ra];
   assign rd_handle = slot_handle_ff[ra];
   assign rd_period = slot_period_ff[ra];
   assign rd_mcount = slot_mcount_ff[ra];
   assign rd_due    = slot_due_ff[ra];
   assign rd_placed = placed_ff[ra];

   assign due_sum  = sat_add32(time_ff, {2'b00, prod_ff});
   assign idle_sum = sat_add32(time_ff, cfg_idle_advance_us);

   assign ins_go    = q_in_range && (rd_due <= new_due_ff);
   assign find_hit  = q_in_range && (q_at_pos == sel_ff);
   assign do_remove = cmd.fire_time || (cmd.find_step && find_hit);
   assign leave_cnt = (rd_mcount != '0) ? rd_mcount - MCW'(1) : '0;

   assign m_addr    = (idx_ff < SCW'(MEMBER_SLOTS)) ? idx_ff[MW-1:0] : '0;
   assign st_m_ok   = st_idx_ff < SCW'(MEMBER_SLOTS);
   assign st_s_ok   = st_idx_ff < SCW'(PERIOD_SLOTS);
   assign scan_eval = cmd.scan_run && st_v_ff;

   always_comb begin
      stat.scan_done   = st_v_ff && (st_idx_ff == SCW'(SL - 1));
      stat.reg_ok      = free_found_ff && (hit_found_ff || fresh_found_ff);
      stat.slot_hit    = hit_found_ff;
      stat.leave_ok    = match_found_ff;
      stat.last_member = rd_mcount <= MCW'(1);
      stat.find_done   = !q_in_range || find_hit;
      stat.paused      = cfg_paused;
      stat.q_empty     = count_ff == '0;
      stat.best_found  = best_found_ff;
      stat.ins_stop    = !ins_go;
   end

   // scan pipeline: address stage, then evaluate stage on registered member reads and direct slot reads
   always_ff @(posedge clock) begin
      if (reset) begin
         st_v_ff <= 1'b0;
         idx_ff  <= '0;
      end else if (cmd.scan_start) begin
         st_v_ff <= 1'b0;
         idx_ff  <= '0;
      end else if (cmd.scan_run) begin
         if (idx_ff < SCW'(SL)) begin
            idx_ff    <= idx_ff + SCW'(1);
            st_v_ff   <= 1'b1;
            st_idx_ff <= idx_ff;
         end else begin
            st_v_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      mv_q <= member_valid_ff[m_addr];
      if (cmd.scan_start) begin
         free_found_ff  <= 1'b0;
         hit_found_ff   <= 1'b0;
         fresh_found_ff <= 1'b0;
         match_found_ff <= 1'b0;
         best_found_ff  <= 1'b0;
      end else if (scan_eval) begin
         if (st_m_ok && !mv_q && !free_found_ff) begin
            free_found_ff <= 1'b1;
            free_m_ff     <= st_idx_ff[MW-1:0];
         end
         if (st_m_ok && mv_q && !match_found_ff && (mem_q[31:0] == id_ff)) begin
            match_found_ff <= 1'b1;
            match_m_ff     <= st_idx_ff[MW-1:0];
            match_slot_ff  <= mem_q[PW+31:32];
         end
         if (st_s_ok && rd_valid && !hit_found_ff && (rd_period == step_ff)) begin
            hit_found_ff <= 1'b1;
            hit_slot_ff  <= ra;
         end
         if (st_s_ok && !rd_valid && !fresh_found_ff) begin
            fresh_found_ff <= 1'b1;
            fresh_slot_ff  <= ra;
         end
         if (st_s_ok && rd_valid && !rd_placed &&
             (!best_found_ff || (rd_handle < best_handle_ff))) begin
            best_found_ff  <= 1'b1;
            best_slot_ff   <= ra;
            best_handle_ff <= rd_handle;
         end
      end
   end

   // member store
   always_ff @(posedge clock) begin
      if (cmd.reg_apply) member_ram[free_m_ff] <= {sel_ff, id_ff};
      mem_q <= member_ram[m_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MEMBER_SLOTS; i++) member_valid_ff[i] <= 1'b0;
      end else if (cmd.reg_apply) begin
         member_valid_ff[free_m_ff] <= 1'b1;
      end else if (cmd.leave_apply) begin
         member_valid_ff[match_m_ff] <= 1'b0;
      end
   end

   // slot table writes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PERIOD_SLOTS; i++) slot_valid_ff[i] <= 1'b0;
      end else if (cmd.reg_apply && !hit_found_ff) begin
         slot_valid_ff[sel_ff] <= 1'b1;
      end else if (cmd.leave_apply && (leave_cnt == '0)) begin
         slot_valid_ff[sel_ff] <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.reg_apply) begin
         if (hit_found_ff) begin
            slot_mcount_ff[sel_ff] <= rd_mcount + MCW'(1);
         end else begin
            slot_handle_ff[sel_ff] <= next_handle_ff;
            slot_period_ff[sel_ff] <= step_ff;
            slot_mcount_ff[sel_ff] <= MCW'(1);
         end
      end
      if (cmd.leave_apply) slot_mcount_ff[sel_ff] <= leave_cnt;
      if (cmd.due_wr) slot_due_ff[sel_ff] <= due_sum;
      if (cmd.rst_init) begin
         for (int i = 0; i < PERIOD_SLOTS; i++) placed_ff[i] <= 1'b0;
      end else if (cmd.rst_pick) begin
         placed_ff[best_slot_ff] <= 1'b1;
      end
   end

   // ordered pending queue
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         qpos_ff  <= '0;
      end else begin
         if (cmd.rst_init) count_ff <= '0;
         else if (cmd.ins_shift) count_ff <= count_ff + CW'(1);
         else if (do_remove) count_ff <= count_ff - CW'(1);

         if (cmd.fire_sel || cmd.leave_apply || cmd.due_wr) qpos_ff <= '0;
         else if (cmd.ins_step && ins_go) qpos_ff <= qpos_ff + CW'(1);
         else if (cmd.find_step && q_in_range && !find_hit) qpos_ff <= qpos_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < PERIOD_SLOTS; j++) begin
         if (cmd.ins_shift) begin
            if (j == int'(qpos_ff)) begin
               pending_ff[j] <= sel_ff;
            end else if (j > int'(qpos_ff) && j <= int'(count_ff)) begin
               pending_ff[j] <= pending_ff[(j > 0) ? j - 1 : 0];
            end
         end else if (do_remove) begin
            if (j >= int'(qpos_ff) && j + 1 < int'(count_ff)) begin
               pending_ff[j] <= pending_ff[(j + 1 < PERIOD_SLOTS) ? j + 1 : j];
            end
         end
      end
   end

   // time and handle counter
   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff        <= '0;
         next_handle_ff <= HANDLE_RESET;
      end else begin
         if (cmd.rst_init) time_ff <= '0;
         else if (cmd.idle_adv) time_ff <= idle_sum;
         else if (cmd.fire_time) time_ff <= rd_due;
         if (cmd.reg_apply && !hit_found_ff) next_handle_ff <= next_handle_ff + 16'd1;
      end
   end

   // item payload and result
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         id_ff     <= req_member_id;
         step_ff   <= req_step_ms;
         prod_ff   <= 30'(req_step_ms) * US_PER_MS;
         status_ff <= STAT_OK;
         handle_ff <= '0;
         fired_ff  <= 1'b0;
      end
      if (cmd.mul_period) prod_ff <= 30'(rd_period) * US_PER_MS;
      if (cmd.stat_full) status_ff <= STAT_FULL;
      if (cmd.stat_not_found) status_ff <= STAT_NOT_FOUND;
      if (cmd.reg_pick) sel_ff <= hit_found_ff ? hit_slot_ff : fresh_slot_ff;
      if (cmd.leave_pick) sel_ff <= match_slot_ff;
      if (cmd.fire_sel) sel_ff <= q_head;
      if (cmd.rst_pick) sel_ff <= best_slot_ff;
      if (cmd.reg_apply) handle_ff <= hit_found_ff ? rd_handle : next_handle_ff;
      if (cmd.leave_apply || cmd.fire_time) handle_ff <= rd_handle;
      if (cmd.fire_time) fired_ff <= 1'b1;
      if (cmd.due_wr) new_due_ff <= due_sum;
   end

   assign rsp_status  = status_ff;
   assign rsp_handle  = handle_ff;
   assign rsp_fired   = fired_ff;
   assign rsp_time_us = time_ff;

endmodule

`default_nettype wire

// ===== rtl/mrpes_ctrl.sv =====
`default_nettype none

module mrpes_ctrl import mrpes_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [1:0]  req_operation,
   input  wire dp_stat_type stat,
   output logic             busy,
   output logic             rsp_valid,
   output dp_cmd_type       cmd
);

   ctrl_state_type state_ff, state_in;
   logic [1:0]     op_ff, op_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= OP_REGISTER;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      cmd       = '0;
      cmd.ra    = RA_SCAN;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               op_in    = req_operation;
               case (req_operation)
                  OP_ADVANCE: state_in = ST_ADV_CHECK;
                  OP_RESTART: state_in = ST_RST_INIT;
                  default:    state_in = ST_SCAN_INIT;
               endcase
            end
         end
         ST_SCAN_INIT: begin
            cmd.scan_start = 1'b1;
            state_in       = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan_run = 1'b1;
            if (stat.scan_done) begin
               case (op_ff)
                  OP_REGISTER: state_in = ST_REG_CHECK;
                  OP_LEAVE:    state_in = ST_LEAVE_CHECK;
                  default:     state_in = ST_RST_PICK;
               endcase
            end
         end
         ST_REG_CHECK: begin
            if (!stat.reg_ok) begin
               cmd.stat_full = 1'b1;
               state_in      = ST_DONE;
            end else begin
               cmd.reg_pick = 1'b1;
               state_in     = ST_REG_APPLY;
            end
         end
         ST_REG_APPLY: begin
            cmd.ra        = RA_SEL;
            cmd.reg_apply = 1'b1;
            state_in      = stat.slot_hit ? ST_DONE : ST_DUE_WR;
         end
         ST_LEAVE_CHECK: begin
            if (!stat.leave_ok) begin
               cmd.stat_not_found = 1'b1;
               state_in           = ST_DONE;
            end else begin
               cmd.leave_pick = 1'b1;
               state_in       = ST_LEAVE_APPLY;
            end
         end
         ST_LEAVE_APPLY: begin
            cmd.ra          = RA_SEL;
            cmd.leave_apply = 1'b1;
            state_in        = stat.last_member ? ST_LEAVE_FIND : ST_DONE;
         end
         ST_LEAVE_FIND: begin
            cmd.find_step = 1'b1;
            if (stat.find_done) state_in = ST_DONE;
         end
         ST_ADV_CHECK: begin
            if (stat.paused) begin
               state_in = ST_DONE;
            end else if (stat.q_empty) begin
               cmd.idle_adv = 1'b1;
               state_in     = ST_DONE;
            end else begin
               cmd.fire_sel = 1'b1;
               state_in     = ST_FIRE_TIME;
            end
         end
         ST_FIRE_TIME: begin
            cmd.ra         = RA_SEL;
            cmd.fire_time  = 1'b1;
            cmd.mul_period = 1'b1;
            state_in       = ST_DUE_WR;
         end
         ST_RST_INIT: begin
            cmd.rst_init = 1'b1;
            state_in     = ST_SCAN_INIT;
         end
         ST_RST_PICK: begin
            if (!stat.best_found) begin
               state_in = ST_DONE;
            end else begin
               cmd.rst_pick = 1'b1;
               state_in     = ST_RST_MUL;
            end
         end
         ST_RST_MUL: begin
            cmd.ra         = RA_SEL;
            cmd.mul_period = 1'b1;
            state_in       = ST_DUE_WR;
         end
         ST_DUE_WR: begin
            cmd.due_wr = 1'b1;
            state_in   = ST_INS_SCAN;
         end
         ST_INS_SCAN: begin
            cmd.ra       = RA_QUEUE;
            cmd.ins_step = 1'b1;
            if (stat.ins_stop) state_in = ST_INS_SHIFT;
         end
         ST_INS_SHIFT: begin
            cmd.ins_shift = 1'b1;
            state_in      = (op_ff == OP_RESTART) ? ST_SCAN_INIT : ST_DONE;
         end
         ST_DONE: begin
            rsp_valid = 1'b1;
            state_in  = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import mrpes_pkg::*;

   // one command as driven on the req_ ports
   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] member;
      logic [19:0] step;
   } sched_cmd_type;

   // one result as seen on the rsp_ ports
   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] handle;
      logic        fired;
      logic [31:0] time_us;
   } sched_result_type;

   localparam int NSLOT = 16;
   localparam int NMEMB = 64;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_operation;
   logic [31:0] req_member_id;
   logic [19:0] req_step_ms;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_handle;
   logic        rsp_fired;
   logic [31:0] rsp_time_us;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   multi_rate_periodic_event_scheduler DUT (
      .clock(clock), .reset(reset),
      .start(start), .busy(busy),
      .req_operation(req_operation), .req_member_id(req_member_id),
      .req_step_ms(req_step_ms),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status), .rsp_handle(rsp_handle),
      .rsp_fired(rsp_fired), .rsp_time_us(rsp_time_us),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // commands waiting for the driver, results waiting for the monitor
   sched_cmd_type    cmd_backlog[$];
   sched_result_type due_results[$];
   int               fail_count;
   int               shown_count;

   // ---------------------------------------------------------------
   // scheduler shadow: tables, ordered pending queue, time, settings
   // ---------------------------------------------------------------
   bit          sh_slot_used[NSLOT];
   logic [15:0] sh_slot_handle[NSLOT];
   logic [19:0] sh_slot_period[NSLOT];
   int          sh_slot_members[NSLOT];
   logic [31:0] sh_slot_due[NSLOT];
   int          sh_pending[NSLOT];
   int          sh_pending_n;
   bit          sh_memb_used[NMEMB];
   logic [31:0] sh_memb_ident[NMEMB];
   int          sh_memb_slot[NMEMB];
   logic [31:0] sh_now;
   logic [15:0] sh_next_handle;
   logic        sh_paused;
   logic [31:0] sh_idle_step;

   function automatic logic [31:0] clamp_add(input logic [31:0] a, input logic [63:0] b);
      logic [63:0] s;
      s = {32'd0, a} + b;
      return (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   // place a slot behind every entry due no later than it
   task automatic pending_insert(input int s);
      int pos;
      if (sh_pending_n >= NSLOT) return;
      pos = 0;
      while (pos < sh_pending_n && sh_slot_due[sh_pending[pos]] <= sh_slot_due[s]) pos++;
      for (int i = sh_pending_n; i > pos; i--) sh_pending[i] = sh_pending[i-1];
      sh_pending[pos] = s;
      sh_pending_n++;
   endtask

   task automatic pending_drop(input int pos);
      if (pos >= sh_pending_n) return;
      for (int i = pos; i + 1 < sh_pending_n; i++) sh_pending[i] = sh_pending[i+1];
      sh_pending_n--;
   endtask

   // work out the result of one accepted command and update the shadow
   task automatic schedule_outcome(input sched_cmd_type c);
      sched_result_type r;
      int m, hit, fresh, s, best;
      bit placed[NSLOT];
      r = '0;
      r.status = STAT_OK;
      case (c.op)
         OP_REGISTER: begin
            m = NMEMB; hit = NSLOT; fresh = NSLOT;
            for (int i = 0; i < NMEMB; i++)
               if (!sh_memb_used[i]) begin m = i; break; end
            for (int i = 0; i < NSLOT; i++)
               if (sh_slot_used[i] && sh_slot_period[i] == c.step) begin hit = i; break; end
            if (hit == NSLOT)
               for (int i = 0; i < NSLOT; i++)
                  if (!sh_slot_used[i]) begin fresh = i; break; end
            if (m == NMEMB || (hit == NSLOT && fresh == NSLOT)) begin
               r.status = STAT_FULL;
            end else begin
               if (hit != NSLOT) begin
                  s = hit;
                  sh_slot_members[s]++;
               end else begin
                  s = fresh;
                  sh_slot_used[s] = 1'b1;
                  sh_slot_handle[s] = sh_next_handle;
                  sh_slot_period[s] = c.step;
                  sh_slot_members[s] = 1;
                  sh_slot_due[s] = clamp_add(sh_now, 64'(c.step) * 1000);
                  sh_next_handle = sh_next_handle + 16'd1;
                  pending_insert(s);
               end
               sh_memb_used[m] = 1'b1;
               sh_memb_ident[m] = c.member;
               sh_memb_slot[m] = s;
               r.handle = sh_slot_handle[s];
            end
         end
         OP_ADVANCE: begin
            if (!sh_paused) begin
               if (sh_pending_n == 0) begin
                  sh_now = clamp_add(sh_now, 64'(sh_idle_step));
               end else begin
                  s = sh_pending[0];
                  sh_now = sh_slot_due[s];
                  r.handle = sh_slot_handle[s];
                  r.fired = 1'b1;
                  sh_slot_due[s] = clamp_add(sh_now, 64'(sh_slot_period[s]) * 1000);
                  pending_drop(0);
                  pending_insert(s);
               end
            end
         end
         OP_LEAVE: begin
            m = NMEMB;
            for (int i = 0; i < NMEMB; i++)
               if (sh_memb_used[i] && sh_memb_ident[i] == c.member) begin m = i; break; end
            if (m == NMEMB) begin
               r.status = STAT_NOT_FOUND;
            end else begin
               s = sh_memb_slot[m];
               sh_memb_used[m] = 1'b0;
               r.handle = sh_slot_handle[s];
               if (sh_slot_members[s] > 0) sh_slot_members[s]--;
               if (sh_slot_members[s] == 0) begin
                  for (int i = 0; i < sh_pending_n; i++)
                     if (sh_pending[i] == s) begin pending_drop(i); break; end
                  sh_slot_used[s] = 1'b0;
               end
            end
         end
         default: begin
            // restart: requeue every live slot in handle order from time zero
            sh_now = '0;
            sh_pending_n = 0;
            for (int i = 0; i < NSLOT; i++) placed[i] = 1'b0;
            forever begin
               best = NSLOT;
               for (int i = 0; i < NSLOT; i++)
                  if (sh_slot_used[i] && !placed[i] &&
                      (best == NSLOT || sh_slot_handle[i] < sh_slot_handle[best]))
                     best = i;
               if (best == NSLOT) break;
               placed[best] = 1'b1;
               sh_slot_due[best] = clamp_add(32'd0, 64'(sh_slot_period[best]) * 1000);
               pending_insert(best);
            end
         end
      endcase
      r.time_us = sh_now;
      due_results.insert(due_results.size(), r);
   endtask

   // ---------------------------------------------------------------
   // driver: bursts of commands separated by random gaps
   // ---------------------------------------------------------------
   int            burst_left;
   int            gap_left;
   bit            taken;
   sched_cmd_type next_cmd;

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         burst_left <= 0;
         gap_left <= 0;
      end else begin
         taken = start && !busy;
         if (taken)
            schedule_outcome('{op: req_operation, member: req_member_id, step: req_step_ms});
         if (!start || taken) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               start <= 1'b0;
            end else if (cmd_backlog.size() > 0) begin
               next_cmd = cmd_backlog[0];
               cmd_backlog.delete(0);
               req_operation <= next_cmd.op;
               req_member_id <= next_cmd.member;
               req_step_ms <= next_cmd.step;
               start <= 1'b1;
               if (burst_left <= 1) begin
                  // new burst; sometimes long runs with no gap at all
                  burst_left <= $urandom_range(1, 12);
                  gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // monitor: every strobed result against the oldest expectation
   // ---------------------------------------------------------------
   sched_result_type want;

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (due_results.size() == 0) begin
            fail_count <= fail_count + 1;
            if (shown_count < 10)
               $display("unexpected result: status %0d handle %0d fired %0d time %0d",
                        rsp_status, rsp_handle, rsp_fired, rsp_time_us);
            shown_count <= shown_count + 1;
         end else begin
            want = due_results[0];
            due_results.delete(0);
            if (want.status !== rsp_status || want.handle !== rsp_handle ||
                want.fired !== rsp_fired || want.time_us !== rsp_time_us) begin
               fail_count <= fail_count + 1;
               if (shown_count < 10)
                  $display("mismatch: exp st %0d h %0d f %0d t %0d / got st %0d h %0d f %0d t %0d",
                           want.status, want.handle, want.fired, want.time_us,
                           rsp_status, rsp_handle, rsp_fired, rsp_time_us);
               shown_count <= shown_count + 1;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // register port transactions
   // ---------------------------------------------------------------
   task automatic csr_write(input logic csr_index, input logic [31:0] value);
      @(posedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= {csr_index, 2'b00}; pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      if (csr_index == CSR_PAUSED) sh_paused = value[0];
      else sh_idle_step = value;
   endtask

   task automatic csr_check(input logic csr_index, input logic [31:0] value);
      logic [31:0] got;
      @(posedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b0; paddr <= {csr_index, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      @(negedge clock);
      while (!pready) @(negedge clock);
      got = prdata;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0;
      if (got !== value) begin
         fail_count++;
         if (shown_count < 10)
            $display("register %0d readback: exp %0h got %0h", csr_index, value, got);
         shown_count++;
      end
   endtask

   task automatic add_cmd(input logic [1:0] op, input logic [31:0] member,
                          input logic [19:0] step);
      sched_cmd_type c;
      c = '{op: op, member: member, step: step};
      cmd_backlog.insert(cmd_backlog.size(), c);
   endtask

   // wait for the block to drain all commands and results
   task automatic drain();
      while (cmd_backlog.size() > 0 || start || due_results.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // ---------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------
   logic [31:0] member_pool[40];
   logic [31:0] idle_plan[7];
   logic [31:0] pick_member;
   logic [19:0] pick_step;
   int          roll;
   int          join_pct;

   initial begin
      fail_count = 0;
      shown_count = 0;
      reset = 1'b1;
      start = 1'b0;
      req_operation = OP_ADVANCE;
      req_member_id = '0;
      req_step_ms = '0;
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
      sh_paused = PAUSED_RESET;
      sh_idle_step = IDLE_ADV_RESET;
      sh_pending_n = 0;
      sh_now = '0;
      sh_next_handle = HANDLE_RESET;
      for (int i = 0; i < NSLOT; i++) sh_slot_used[i] = 1'b0;
      for (int i = 0; i < NMEMB; i++) sh_memb_used[i] = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      csr_check(CSR_PAUSED, 32'd1);
      csr_check(CSR_IDLE_ADV, IDLE_ADV_RESET);

      // paused after reset: registration, joins, duplicates, misses, restart
      add_cmd(OP_REGISTER, 32'h0000_0000, 20'd0);
      add_cmd(OP_REGISTER, 32'hFFFF_FFFF, 20'hFFFFF);
      add_cmd(OP_REGISTER, 32'd5, 20'd0);              // joins the zero period slot
      add_cmd(OP_REGISTER, 32'h0000_0000, 20'd7);      // same member twice
      add_cmd(OP_ADVANCE, 32'd0, 20'd0);               // paused: nothing fires
      add_cmd(OP_LEAVE, 32'd12345, 20'd0);             // unknown member
      add_cmd(OP_LEAVE, 32'h0000_0000, 20'd0);         // lowest matching entry goes
      add_cmd(OP_RESTART, 32'd0, 20'd0);
      add_cmd(OP_REGISTER, 32'hA5A5_A5A5, 20'h5A5A5);
      drain();
      csr_write(CSR_PAUSED, 32'd0);
      csr_check(CSR_PAUSED, 32'd0);

      // running: zero period refires at the same time, slot teardown, idle step
      repeat (4) add_cmd(OP_ADVANCE, 32'd0, 20'd0);
      add_cmd(OP_LEAVE, 32'd5, 20'd0);
      add_cmd(OP_LEAVE, 32'h0000_0000, 20'd0);
      add_cmd(OP_ADVANCE, 32'd0, 20'd0);
      add_cmd(OP_ADVANCE, 32'd0, 20'd0);               // 0x5A5A5 ms slot fires again
      add_cmd(OP_LEAVE, 32'hFFFF_FFFF, 20'd0);
      add_cmd(OP_LEAVE, 32'hA5A5_A5A5, 20'd0);
      add_cmd(OP_ADVANCE, 32'd0, 20'd0);               // empty queue: idle step
      add_cmd(OP_RESTART, 32'd0, 20'd0);
      drain();

      idle_plan[0] = 32'd0;
      idle_plan[1] = 32'hFFFF_FFFF;
      idle_plan[2] = $urandom;
      idle_plan[3] = 32'd1;
      idle_plan[4] = IDLE_ADV_RESET;
      idle_plan[5] = $urandom_range(0, 5000);
      idle_plan[6] = 32'hFFFF_FFFF;

      for (int ph = 0; ph < 7; ph++) begin
         csr_write(CSR_IDLE_ADV, idle_plan[ph]);
         csr_write(CSR_PAUSED, (ph == 3) ? 32'd1 : 32'd0);
         csr_check(CSR_IDLE_ADV, idle_plan[ph]);
         // fresh member names each phase, the extremes included
         for (int i = 0; i < 40; i++) member_pool[i] = $urandom;
         member_pool[0] = 32'h0000_0000;
         member_pool[1] = 32'hFFFF_FFFF;
         // odd phases lean on registration so the tables fill up
         join_pct = (ph % 2) ? 62 : 35;
         for (int n = 0; n < 200; n++) begin
            roll = $urandom_range(0, 99);
            pick_member = ($urandom_range(0, 99) < 85) ?
                          member_pool[$urandom_range(0, 39)] : $urandom;
            case ($urandom_range(0, 9))
               0: pick_step = $urandom_range(0, 20'hFFFFF);
               1: pick_step = ($urandom_range(0, 1) == 0) ? 20'd0 : 20'hFFFFF;
               default: pick_step = 20'($urandom_range(0, 19) * 37);
            endcase
            if (roll < join_pct) add_cmd(OP_REGISTER, pick_member, pick_step);
            else if (roll < join_pct + 40) add_cmd(OP_ADVANCE, $urandom, $urandom);
            else if (roll < 97) add_cmd(OP_LEAVE, pick_member, $urandom);
            else add_cmd(OP_RESTART, $urandom, $urandom);
         end
         drain();
      end

      repeat (100) @(posedge clock);
      if (fail_count == 0 && due_results.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // watchdog
   initial begin
      #40ms;
      $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/mrpes_pkg.sv
rtl/mrpes_datapath.sv
rtl/mrpes_ctrl.sv
rtl/multi_rate_periodic_event_scheduler.sv
verif/tb_top.sv
